@@ hw/rtl/mtee_pkg.sv @@
// Package for the MIDI track event encoder: transaction payload types,
// event function codes and SMF byte constants. No dependencies.
package mtee_pkg;

    typedef enum logic [2:0] {
        FUNC_START    = 3'd0,
        FUNC_TEMPO    = 3'd1,
        FUNC_KEY      = 3'd2,
        FUNC_TIMESIG  = 3'd3,
        FUNC_PROGRAM  = 3'd4,
        FUNC_NOTE_ON  = 3'd5,
        FUNC_NOTE_OFF = 3'd6,
        FUNC_END      = 3'd7
    } t_func;

    typedef struct packed {
        logic [2:0]  func;
        logic [27:0] delta;
        logic [3:0]  channel;
        logic [7:0]  arg_a;
        logic [7:0]  arg_b;
        logic [23:0] tempo_us;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last;
        logic [31:0] track_length;
    } t_out;

    localparam logic [7:0] ST_PROGRAM  = 8'hC0;
    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] META        = 8'hFF;
    localparam logic [7:0] META_END    = 8'h2F;
    localparam logic [7:0] META_SET_TEMPO = 8'h51;
    localparam logic [7:0] META_TIME   = 8'h58;
    localparam logic [7:0] META_KEY    = 8'h59;
    localparam logic [7:0] VLQ_CONT    = 8'h80;
    localparam logic [6:0] VLQ_MASK    = 7'h7F;
    localparam logic [7:0] CLOCKS_PER_CLICK = 8'd24;
    localparam logic [7:0] NOTES_32_PER_Q   = 8'd8;
    localparam logic [7:0] HDR_M = 8'h4D;
    localparam logic [7:0] HDR_T = 8'h54;
    localparam logic [7:0] HDR_R = 8'h72;
    localparam logic [7:0] HDR_K = 8'h6B;
    localparam logic [3:0] HDR_LEN = 4'd8;

endpackage

@@ hw/rtl/midi_track_event_encoder_unit.sv @@
// MIDI track event encoder top level: turns one track event transaction into
// its Standard MIDI File bytes, one byte per output transaction.
// Depends on mtee_pkg for payload types and constants.
// Flow: an accepted event lands in the event register; its bytes then move
//   one at a time into the output register, which holds while stalled.
// Events: n bytes each (3 to 11; start is 8); the next event enters as the
//   last byte moves out, so events stream with no gap.
// Reset: synchronous, active low; clears the event and output valid flags,
//   the byte index and the running track byte count.
module midi_track_event_encoder_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  mtee_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output mtee_pkg::t_out  o_out_data
);

    // Event register and the index of the next byte to emit from it
    mtee_pkg::t_in  r_evt;
    logic           r_evt_vld;
    logic [3:0]     r_idx;

    // Output register and running count of bytes since the header
    mtee_pkg::t_out r_out;
    logic           r_out_vld;
    logic [31:0]    r_count;

    logic [6:0]     g3, g2, g1, g0;
    logic [2:0]     vlq_len;
    logic [1:0]     vlq_sel;
    logic [7:0]     vlq_byte;
    logic [3:0]     body_idx;
    logic [7:0]     body_byte;
    logic [3:0]     body_len;
    logic [3:0]     total_len;
    logic [7:0]     cur_byte;
    logic           cur_last;
    logic           is_start;
    logic           out_load;
    logic           evt_done;
    logic           in_accept;
    mtee_pkg::t_func func;

    assign func     = mtee_pkg::t_func'(r_evt.func);
    assign is_start = (func == mtee_pkg::FUNC_START);

    // Split the delta into 7-bit groups, most significant first
    always_comb begin
        g3 = r_evt.delta[27:21] & mtee_pkg::VLQ_MASK;
        g2 = r_evt.delta[20:14] & mtee_pkg::VLQ_MASK;
        g1 = r_evt.delta[13:7]  & mtee_pkg::VLQ_MASK;
        g0 = r_evt.delta[6:0]   & mtee_pkg::VLQ_MASK;
        if (g3 != 7'd0) begin
            vlq_len = 3'd4;
        end else if (g2 != 7'd0) begin
            vlq_len = 3'd3;
        end else if (g1 != 7'd0) begin
            vlq_len = 3'd2;
        end else begin
            vlq_len = 3'd1;
        end
        // Skip the leading zero groups: byte k is group (k + 4 - len)
        vlq_sel = r_idx[1:0] + 2'(3'd4 - vlq_len);
        case (vlq_sel)
            2'd0:    vlq_byte = mtee_pkg::VLQ_CONT | {1'b0, g3};
            2'd1:    vlq_byte = mtee_pkg::VLQ_CONT | {1'b0, g2};
            2'd2:    vlq_byte = mtee_pkg::VLQ_CONT | {1'b0, g1};
            default: vlq_byte = {1'b0, g0};
        endcase
    end

    // Select the event body byte after the delta
    always_comb begin
        body_idx  = r_idx - {1'b0, vlq_len};
        body_byte = 8'h00;
        body_len  = 4'd3;
        case (func)
            mtee_pkg::FUNC_TEMPO: begin
                body_len = 4'd6;
                case (body_idx)
                    4'd0:    body_byte = mtee_pkg::META;
                    4'd1:    body_byte = mtee_pkg::META_SET_TEMPO;
                    4'd2:    body_byte = 8'd3;
                    4'd3:    body_byte = r_evt.tempo_us[23:16];
                    4'd4:    body_byte = r_evt.tempo_us[15:8];
                    default: body_byte = r_evt.tempo_us[7:0];
                endcase
            end
            mtee_pkg::FUNC_KEY: begin
                body_len = 4'd5;
                case (body_idx)
                    4'd0:    body_byte = mtee_pkg::META;
                    4'd1:    body_byte = mtee_pkg::META_KEY;
                    4'd2:    body_byte = 8'd2;
                    4'd3:    body_byte = r_evt.arg_a;
                    default: body_byte = r_evt.arg_b;
                endcase
            end
            mtee_pkg::FUNC_TIMESIG: begin
                body_len = 4'd7;
                case (body_idx)
                    4'd0:    body_byte = mtee_pkg::META;
                    4'd1:    body_byte = mtee_pkg::META_TIME;
                    4'd2:    body_byte = 8'd4;
                    4'd3:    body_byte = r_evt.arg_a;
                    4'd4:    body_byte = r_evt.arg_b;
                    4'd5:    body_byte = mtee_pkg::CLOCKS_PER_CLICK;
                    default: body_byte = mtee_pkg::NOTES_32_PER_Q;
                endcase
            end
            mtee_pkg::FUNC_PROGRAM: begin
                body_len = 4'd2;
                case (body_idx)
                    4'd0:    body_byte = mtee_pkg::ST_PROGRAM | {4'h0, r_evt.channel};
                    default: body_byte = r_evt.arg_a;
                endcase
            end
            mtee_pkg::FUNC_NOTE_ON: begin
                body_len = 4'd3;
                case (body_idx)
                    4'd0:    body_byte = mtee_pkg::ST_NOTE_ON | {4'h0, r_evt.channel};
                    4'd1:    body_byte = r_evt.arg_a;
                    default: body_byte = r_evt.arg_b;
                endcase
            end
            mtee_pkg::FUNC_NOTE_OFF: begin
                body_len = 4'd3;
                case (body_idx)
                    4'd0:    body_byte = mtee_pkg::ST_NOTE_OFF | {4'h0, r_evt.channel};
                    4'd1:    body_byte = r_evt.arg_a;
                    default: body_byte = r_evt.arg_b;
                endcase
            end
            mtee_pkg::FUNC_END: begin
                body_len = 4'd3;
                case (body_idx)
                    4'd0:    body_byte = mtee_pkg::META;
                    4'd1:    body_byte = mtee_pkg::META_END;
                    default: body_byte = 8'h00;
                endcase
            end
            default: begin
                body_len  = 4'd3;
                body_byte = 8'h00;
            end
        endcase
    end

    // Pick header, delta or body byte and flag the final byte of the event
    always_comb begin
        if (is_start) begin
            total_len = mtee_pkg::HDR_LEN;
            case (r_idx)
                4'd0:    cur_byte = mtee_pkg::HDR_M;
                4'd1:    cur_byte = mtee_pkg::HDR_T;
                4'd2:    cur_byte = mtee_pkg::HDR_R;
                4'd3:    cur_byte = mtee_pkg::HDR_K;
                default: cur_byte = 8'h00;
            endcase
        end else begin
            total_len = {1'b0, vlq_len} + body_len;
            cur_byte  = (r_idx < {1'b0, vlq_len}) ? vlq_byte : body_byte;
        end
        cur_last = (r_idx == total_len - 4'd1);
    end

    // Advance one byte whenever the output register is free or being drained;
    // take the next event as the last byte of this one leaves
    assign out_load   = r_evt_vld && (!r_out_vld || !i_out_stall);
    assign evt_done   = out_load && cur_last;
    assign o_in_stall = r_evt_vld && !evt_done;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evt_vld <= 1'b0;
            r_idx     <= 4'd0;
            r_out_vld <= 1'b0;
            r_count   <= 32'd0;
        end else begin
            if (in_accept) begin
                r_evt_vld <= 1'b1;
                r_idx     <= 4'd0;
            end else if (evt_done) begin
                r_evt_vld <= 1'b0;
                r_idx     <= 4'd0;
            end else if (out_load) begin
                r_idx <= r_idx + 4'd1;
            end

            if (out_load) begin
                r_out_vld <= 1'b1;
                // Header resets the count and is not counted itself
                r_count   <= is_start ? 32'd0 : r_count + 32'd1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers: hold while stalled
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_evt <= i_in_data;
        end
        if (out_load) begin
            r_out.out_byte     <= cur_byte;
            r_out.last         <= cur_last;
            r_out.track_length <= is_start ? 32'd0 : r_count + 32'd1;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
